@@ design/gcsl_pkg.sv @@
// shared types and codes for the grid component size labeler
// no dependencies
package gcsl_pkg;

    // configuration register width and register indexes (paddr bit 2)
    localparam int CFG_W = 7;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // request codes on req_type
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // payload widths on the ports
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_LOAD_LABEL,
        CMD_LABEL,
        CMD_READ
    } cmd_kind_t;

    // neighbor directions, visited in this order
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_DOWN  = 2'd0;
    localparam dir_t DIR_LEFT  = 2'd1;
    localparam dir_t DIR_UP    = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

    // back end sequencer states
    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN_RD,
        B_SCAN_EV,
        B_SCAN_ADV,
        B_POP,
        B_NBR,
        B_NEVAL,
        B_WB,
        B_DONE
    } back_state_t;

endpackage

@@ design/gcsl_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module gcsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/gcsl_cmd_queue.sv @@
// short command queue between front and back
// no dependencies
module gcsl_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNTW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ design/gcsl_front.sv @@
// front end: config registers, request classification, load and read counters
// depends on gcsl_pkg
module gcsl_front import gcsl_pkg::*; #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 16,
    parameter int CMD_W      = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             req_type,
    input  logic [IN_W-1:0]  cell_value,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             q_full,
    output logic             q_push,
    output logic [CMD_W-1:0] q_din,
    input  logic             label_done
);

    localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW  = $clog2(MAX_CELLS);
    localparam int NW  = $clog2(MAX_CELLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CNW = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic             cfg_wr;
    logic [RNW-1:0]   eff_rows;
    logic [CNW-1:0]   eff_cols;
    logic [NW-1:0]    total;

    logic [NW-1:0]    lc_reg, lc_next, rc_reg, rc_next;
    logic             done_reg, done_next;
    logic             pending_reg, pending_next;
    logic             accept;

    logic [NW-1:0]    lc_base, lc_after;
    logic             store;
    cmd_kind_t        kind;
    logic             last;
    logic [AW-1:0]    idx;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= CFG_W'(64);
            cols_cfg_reg <= CFG_W'(64);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_COLS)
            begin
                cols_cfg_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                rows_cfg_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_cfg_reg) : 32'(rows_cfg_reg);

    // effective grid size, zero acts as one and large values clamp
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            eff_rows = RNW'(1);
        end
        else if (rows_cfg_reg > MAX_ROWS)
        begin
            eff_rows = RNW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = RNW'(rows_cfg_reg);
        end
        if (cols_cfg_reg == '0)
        begin
            eff_cols = CNW'(1);
        end
        else if (cols_cfg_reg > MAX_COLS)
        begin
            eff_cols = CNW'(MAX_COLS);
        end
        else
        begin
            eff_cols = CNW'(cols_cfg_reg);
        end
    end

    assign total  = NW'(NW'(eff_rows) * NW'(eff_cols));
    assign busy   = q_full || pending_reg;
    assign accept = start && !busy;

    // classify the beat and advance the counters
    always_comb
    begin
        lc_next      = lc_reg;
        rc_next      = rc_reg;
        done_next    = done_reg;
        pending_next = pending_reg;
        q_push       = 1'b0;
        kind         = CMD_LOAD;
        last         = 1'b0;
        idx          = '0;
        lc_base      = done_reg ? '0 : lc_reg;
        store        = (lc_base < total);
        lc_after     = store ? lc_base + 1'b1 : lc_base;

        if (label_done)
        begin
            pending_next = 1'b0;
        end

        if (accept)
        begin
            if (req_type == REQ_LOAD)
            begin
                q_push = 1'b1;
                idx    = lc_base[AW-1:0];
                if (done_reg)
                begin
                    rc_next = '0;
                end
                lc_next = lc_after;
                if (lc_after >= total)
                begin
                    done_next    = 1'b1;
                    pending_next = 1'b1;
                    kind         = store ? CMD_LOAD_LABEL : CMD_LABEL;
                end
                else
                begin
                    done_next = 1'b0;
                    kind      = CMD_LOAD;
                end
            end
            else if (done_reg)
            begin
                q_push = 1'b1;
                kind   = CMD_READ;
                idx    = rc_reg[AW-1:0];
                last   = ((rc_reg + 1'b1) >= total);
                if (last)
                begin
                    done_next = 1'b0;
                    lc_next   = '0;
                    rc_next   = '0;
                end
                else
                begin
                    rc_next = rc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg      <= '0;
            rc_reg      <= '0;
            done_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            lc_reg      <= lc_next;
            rc_reg      <= rc_next;
            done_reg    <= done_next;
            pending_reg <= pending_next;
        end
    end

    assign q_din = {kind, last, idx, VALUE_BITS'(cell_value), eff_rows, eff_cols};

endmodule

@@ design/gcsl_back.sv @@
// back end: grid store, search queue and the labeling sequencer
// depends on gcsl_pkg and gcsl_ram
module gcsl_back import gcsl_pkg::*; #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 16,
    parameter int CMD_W      = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic [CMD_W-1:0] q_dout,
    output logic             label_done,
    output logic             result_valid,
    output logic [OUT_W-1:0] cell_out,
    output logic             grid_last
);

    localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW  = $clog2(MAX_CELLS);
    localparam int NW  = $clog2(MAX_CELLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int VB  = VALUE_BITS;
    localparam int GW  = VB + 1;
    localparam int QW  = RW + CW + AW;
    localparam int SW  = (NW > VB) ? NW : VB;

    // command fields
    cmd_kind_t      c_kind;
    logic           c_last;
    logic [AW-1:0]  c_idx;
    logic [VB-1:0]  c_value;
    logic [RNW-1:0] c_rows;
    logic [CNW-1:0] c_cols;

    assign c_kind  = cmd_kind_t'(q_dout[CMD_W-1 -: 2]);
    assign c_last  = q_dout[CMD_W-3];
    assign c_idx   = q_dout[CNW + RNW + VB +: AW];
    assign c_value = q_dout[CNW + RNW +: VB];
    assign c_rows  = q_dout[CNW +: RNW];
    assign c_cols  = q_dout[CNW-1:0];

    // memory ports
    logic          g_we, g_re;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [GW-1:0] g_wdata, g_rdata;
    logic          s_we, s_re;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [QW-1:0] s_wdata, s_rdata;

    gcsl_ram #(.WIDTH(GW), .DEPTH(MAX_CELLS)) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gcsl_ram #(.WIDTH(QW), .DEPTH(MAX_CELLS)) u_search_q (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // sequencer state
    back_state_t    state_reg, state_next;
    logic [RNW-1:0] rows_reg, rows_next;
    logic [CNW-1:0] cols_reg, cols_next;
    logic [NW-1:0]  scan_reg, scan_next;
    logic [RW-1:0]  sr_reg, sr_next;
    logic [CW-1:0]  sc_reg, sc_next;
    logic [NW-1:0]  head_reg, head_next;
    logic [NW-1:0]  tail_reg, tail_next;
    dir_t           dir_reg, dir_next;
    logic           ev_valid_reg, ev_valid_next;
    logic [RW-1:0]  ev_r_reg, ev_r_next;
    logic [CW-1:0]  ev_c_reg, ev_c_next;
    logic [AW-1:0]  ev_idx_reg, ev_idx_next;
    logic [NW-1:0]  k_reg, k_next;
    logic           wbv_reg, wbv_next;
    logic           res_valid_reg, res_valid_next;
    logic           res_last_reg, res_last_next;

    logic [NW-1:0]  total;
    logic           ev_hit;
    logic [SW-1:0]  tail_ext, vmask_ext;
    logic [VB-1:0]  size;

    // neighbor of the cell at the head of the search
    logic [RW-1:0]  cur_r, nb_r;
    logic [CW-1:0]  cur_c, nb_c;
    logic [AW-1:0]  cur_idx, nb_idx;
    logic           nb_in;

    assign total     = NW'(NW'(rows_reg) * NW'(cols_reg));
    assign ev_hit    = ev_valid_reg && (g_rdata == '0);
    assign tail_ext  = SW'(tail_reg);
    assign vmask_ext = SW'({VB{1'b1}});
    assign size      = (tail_ext > vmask_ext) ? {VB{1'b1}} : VB'(tail_ext);

    assign cur_idx = s_rdata[AW-1:0];
    assign cur_c   = s_rdata[AW +: CW];
    assign cur_r   = s_rdata[AW + CW +: RW];

    always_comb
    begin
        nb_r   = cur_r;
        nb_c   = cur_c;
        nb_idx = cur_idx;
        nb_in  = 1'b0;
        case (dir_reg)
            DIR_DOWN:
            begin
                nb_in  = ((RNW + 1)'(cur_r) + 1) < (RNW + 1)'(rows_reg);
                nb_r   = cur_r + 1'b1;
                nb_idx = cur_idx + AW'(cols_reg);
            end
            DIR_LEFT:
            begin
                nb_in  = (cur_c != '0);
                nb_c   = cur_c - 1'b1;
                nb_idx = cur_idx - 1'b1;
            end
            DIR_UP:
            begin
                nb_in  = (cur_r != '0);
                nb_r   = cur_r - 1'b1;
                nb_idx = cur_idx - AW'(cols_reg);
            end
            default:
            begin
                nb_in  = ((CNW + 1)'(cur_c) + 1) < (CNW + 1)'(cols_reg);
                nb_c   = cur_c + 1'b1;
                nb_idx = cur_idx + 1'b1;
            end
        endcase
    end

    // next state and memory controls
    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        scan_next      = scan_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        dir_next       = dir_reg;
        ev_valid_next  = ev_valid_reg;
        ev_r_next      = ev_r_reg;
        ev_c_next      = ev_c_reg;
        ev_idx_next    = ev_idx_reg;
        k_next         = k_reg;
        wbv_next       = wbv_reg;
        res_valid_next = 1'b0;
        res_last_next  = res_last_reg;
        q_pop          = 1'b0;
        g_we           = 1'b0;
        g_waddr        = '0;
        g_wdata        = '0;
        g_re           = 1'b0;
        g_raddr        = '0;
        s_we           = 1'b0;
        s_waddr        = '0;
        s_wdata        = '0;
        s_re           = 1'b0;
        s_raddr        = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (c_kind)
                        CMD_LOAD, CMD_LOAD_LABEL:
                        begin
                            g_we    = 1'b1;
                            g_waddr = c_idx;
                            g_wdata = {1'b0, c_value};
                        end
                        CMD_READ:
                        begin
                            g_re           = 1'b1;
                            g_raddr        = c_idx;
                            res_valid_next = 1'b1;
                            res_last_next  = c_last;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (c_kind == CMD_LOAD_LABEL || c_kind == CMD_LABEL)
                    begin
                        rows_next  = c_rows;
                        cols_next  = c_cols;
                        scan_next  = '0;
                        sr_next    = '0;
                        sc_next    = '0;
                        state_next = B_SCAN_RD;
                    end
                end
            end

            // raster scan for an unvisited open cell
            B_SCAN_RD:
            begin
                g_re       = 1'b1;
                g_raddr    = scan_reg[AW-1:0];
                state_next = B_SCAN_EV;
            end

            B_SCAN_EV:
            begin
                if (g_rdata == '0)
                begin
                    g_we       = 1'b1;
                    g_waddr    = scan_reg[AW-1:0];
                    g_wdata    = {1'b1, {VB{1'b0}}};
                    s_we       = 1'b1;
                    s_waddr    = '0;
                    s_wdata    = {sr_reg, sc_reg, scan_reg[AW-1:0]};
                    head_next  = '0;
                    tail_next  = NW'(1);
                    state_next = B_POP;
                end
                else
                begin
                    state_next = B_SCAN_ADV;
                end
            end

            B_SCAN_ADV:
            begin
                if ((scan_reg + 1'b1) >= total)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    if (((CNW + 1)'(sc_reg) + 1) == (CNW + 1)'(cols_reg))
                    begin
                        sc_next = '0;
                        sr_next = sr_reg + 1'b1;
                    end
                    else
                    begin
                        sc_next = sc_reg + 1'b1;
                    end
                    state_next = B_SCAN_RD;
                end
            end

            // take the next cell off the search queue
            B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    s_re       = 1'b1;
                    s_raddr    = head_reg[AW-1:0];
                    head_next  = head_reg + 1'b1;
                    dir_next   = DIR_DOWN;
                    state_next = B_NBR;
                end
                else if (tail_reg > NW'(1))
                begin
                    k_next     = '0;
                    wbv_next   = 1'b0;
                    state_next = B_WB;
                end
                else
                begin
                    state_next = B_SCAN_ADV;
                end
            end

            // read one neighbor per cycle, judge the previous one
            B_NBR:
            begin
                g_re          = nb_in;
                g_raddr       = nb_idx;
                ev_valid_next = nb_in;
                ev_r_next     = nb_r;
                ev_c_next     = nb_c;
                ev_idx_next   = nb_idx;
                if (dir_reg == DIR_RIGHT)
                begin
                    state_next = B_NEVAL;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end

            B_NEVAL:
            begin
                ev_valid_next = 1'b0;
                state_next    = B_POP;
            end

            // write the component size back over every member
            B_WB:
            begin
                if (k_reg < tail_reg)
                begin
                    s_re     = 1'b1;
                    s_raddr  = k_reg[AW-1:0];
                    k_next   = k_reg + 1'b1;
                    wbv_next = 1'b1;
                end
                else
                begin
                    wbv_next = 1'b0;
                end
                if (wbv_reg)
                begin
                    g_we    = 1'b1;
                    g_waddr = s_rdata[AW-1:0];
                    g_wdata = {1'b1, size};
                end
                if (k_reg == tail_reg && !wbv_reg)
                begin
                    state_next = B_SCAN_ADV;
                end
            end

            B_DONE:
            begin
                state_next = B_IDLE;
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // mark and enqueue an open unvisited neighbor
        if ((state_reg == B_NBR || state_reg == B_NEVAL) && ev_hit)
        begin
            g_we    = 1'b1;
            g_waddr = ev_idx_reg;
            g_wdata = {1'b1, {VB{1'b0}}};
            if (tail_reg < NW'(MAX_CELLS))
            begin
                s_we      = 1'b1;
                s_waddr   = tail_reg[AW-1:0];
                s_wdata   = {ev_r_reg, ev_c_reg, ev_idx_reg};
                tail_next = tail_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ev_valid_reg  <= 1'b0;
            wbv_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ev_valid_reg  <= ev_valid_next;
            wbv_reg       <= wbv_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
        scan_reg     <= scan_next;
        sr_reg       <= sr_next;
        sc_reg       <= sc_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        dir_reg      <= dir_next;
        ev_r_reg     <= ev_r_next;
        ev_c_reg     <= ev_c_next;
        ev_idx_reg   <= ev_idx_next;
        k_reg        <= k_next;
        res_last_reg <= res_last_next;
    end

    assign label_done   = (state_reg == B_DONE);
    assign result_valid = res_valid_reg;
    assign grid_last    = res_last_reg;
    assign cell_out     = OUT_W'(g_rdata[VB-1:0]);

endmodule

@@ design/grid_component_size_labeler.sv @@
// grid component size labeler: a load or read beat is taken when start is high and busy low;
// a read result strobes once the back end has read the grid store for its beat. labeling
// starts on the last load and holds busy through the scan, search and write back passes.
// no clearing pass: loads clear visited marks.
// rst_n is asynchronous: config returns to 64 x 64, counters and queue empty, busy low.
module grid_component_size_labeler import gcsl_pkg::*; #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             req_type,
    input  logic [IN_W-1:0]  cell_value,
    output logic             result_valid,
    output logic [OUT_W-1:0] cell_out,
    output logic             grid_last,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(MAX_CELLS);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int CNW   = $clog2(MAX_COLS + 1);
    localparam int CMD_W = 2 + 1 + AW + VALUE_BITS + RNW + CNW;

    logic             q_push, q_pop, q_empty, q_full, label_done;
    logic [CMD_W-1:0] q_din, q_dout;

    // request classification
    gcsl_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .cell_value (cell_value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_din      (q_din),
        .label_done (label_done)
    );

    // command queue
    gcsl_cmd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    // storage and labeling
    gcsl_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_dout       (q_dout),
        .label_done   (label_done),
        .result_valid (result_valid),
        .cell_out     (cell_out),
        .grid_last    (grid_last)
    );

endmodule

@@ design/gcsl_checker.sv @@
// port level checks for the grid component size labeler
// depends on gcsl_pkg; bound to grid_component_size_labeler
module gcsl_checker import gcsl_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             req_type,
    input logic [IN_W-1:0]  cell_value,
    input logic             result_valid,
    input logic [OUT_W-1:0] cell_out,
    input logic             grid_last,
    input logic             psel,
    input logic             penable,
    input logic             pwrite,
    input logic [2:0]       paddr,
    input logic [31:0]      pwdata,
    input logic [31:0]      prdata,
    input logic             pready
);

    // config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // a rows write reads back at once
    a_rows_rb: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && $past(psel && penable && pwrite && paddr[2] == REG_ROWS)
         && paddr[2] == REG_ROWS)
        |-> prdata == {25'd0, $past(pwdata[6:0])})
        else $error("rows register readback mismatch");

    // out of reset the block takes beats
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !busy)
        else $error("busy right after reset");

    // the last cell of a grid is never followed at once by another result
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && grid_last) |=> !result_valid)
        else $error("result right after last cell");

endmodule

bind grid_component_size_labeler gcsl_checker u_gcsl_checker (.*);
